// File: rtl/macs_pkg.sv
// Package for the moving average crossover block: widths, depths, codes.
// No dependencies.
package macs_pkg;
  localparam int DEPTH = 1024;
  localparam int AW = 10;
  localparam int CONFIRM = 100;
  localparam int MIN_HIST = 500;
  localparam int TW = 48;
  localparam int PW = 40;
  localparam int SW = 51;
  localparam int CW = 11;
  localparam int MW = 11;
  localparam logic [0:0] REG_SHORT = 1'd0;
  localparam logic [0:0] REG_LONG = 1'd1;
  localparam logic [1:0] SIG_NONE = 2'd0;
  localparam logic [1:0] SIG_BUY = 2'd1;
  localparam logic [1:0] SIG_SELL = 2'd2;

  typedef struct packed {
    logic [TW-1:0] t;
    logic [PW-1:0] p;
    logic          d;
  } entry_t;

  typedef struct packed {
    logic          start;
    logic [SW-1:0] dividend;
    logic [CW-1:0] divisor;
  } div_req_t;
endpackage

// File: rtl/macs_if.sv
// Valid/ready channel interfaces for ticks and results.
// Depends on macs_pkg.
interface macs_tick_if;
  import macs_pkg::*;
  logic valid;
  logic ready;
  logic [TW-1:0] tick_time;
  logic [PW-1:0] tick_price;
  modport source (output valid, tick_time, tick_price, input ready);
  modport sink (input valid, tick_time, tick_price, output ready);
endinterface

interface macs_result_if;
  import macs_pkg::*;
  logic valid;
  logic ready;
  logic [PW-1:0] short_average;
  logic [PW-1:0] long_average;
  logic          short_above_long;
  logic [1:0]    signal;
  modport source (output valid, short_average, long_average, short_above_long, signal,
                  input ready);
  modport sink (input valid, short_average, long_average, short_above_long, signal,
                output ready);
endinterface

// File: rtl/macs_hist_mem.sv
// History ring memory: one write port, one registered read port.
// Depends on macs_pkg.
module macs_hist_mem
  import macs_pkg::*;
(
  input  logic         clk,
  input  logic         we,
  input  logic [AW-1:0] waddr,
  input  entry_t       wdata,
  input  logic [AW-1:0] raddr,
  output entry_t       rdata
);
  entry_t mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/macs_div.sv
// Restoring divider, one quotient bit per cycle; quotient truncated to price width.
// Depends on macs_pkg.
module macs_div
  import macs_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  div_req_t      req,
  output logic          done,
  output logic [PW-1:0] quotient
);
  logic [SW-1:0] quo;
  logic [CW:0]   rem;
  logic [CW-1:0] dvs;
  logic [5:0]    cnt;
  logic          busy;
  logic [CW+1:0] trial;

  assign trial = {rem, quo[SW-1]} - {2'b0, dvs};
  assign quotient = quo[PW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= 6'(SW);
        quo <= req.dividend;
        rem <= '0;
        dvs <= req.divisor;
      end else if (busy) begin
        if (!trial[CW+1]) begin
          rem <= trial[CW:0];
          quo <= {quo[SW-2:0], 1'b1};
        end else begin
          rem <= {rem[CW-1:0], quo[SW-1]};
          quo <= {quo[SW-2:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// File: rtl/moving_average_cross_signal.sv
// Top level of the moving average crossover block.
// Depends on macs_pkg, macs_if, macs_hist_mem, macs_div.
//
//   channel | dir | payload
//   tick    | in  | tick_time[47:0], tick_price[39:0]
//   result  | out | short_average, long_average, short_above_long, signal
//   cfg     | in  | cfg_we, cfg_index, cfg_data[10:0]
//
// One tick at a time. The history scan reads one ring entry per cycle from the
// single read port, newest first, until both windows close and the confirm
// run is checked, or the stored entries run out. Then two divisions run
// back to back. Reset is synchronous; the ring is not cleared, only the fill
// count. The result register holds its beat until taken; a new tick is
// accepted only after the result is taken.
module moving_average_cross_signal
  import macs_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  macs_tick_if.sink     tick,
  macs_result_if.source result,
  input  logic          cfg_we,
  input  logic [0:0]    cfg_index,
  input  logic [MW-1:0] cfg_data
);
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_DIVS  = 6'b000100,
    S_DIVL  = 6'b001000,
    S_WRITE = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state;
  logic [MW-1:0] short_min, long_min;
  logic [AW-1:0] newest_slot;
  logic [AW:0]   stored_count;
  logic [TW-1:0] now;
  logic [PW-1:0] price;
  logic [TW-1:0] short_edge, long_edge;
  // scan bookkeeping
  logic [AW:0]   k;          // entries issued
  logic          rd_pend;    // rdata holds valid read data
  logic [AW:0]   k_rd;       // index of data in flight
  logic          s_open, l_open;
  logic [SW-1:0] s_sum, l_sum;
  logic [CW-1:0] s_cnt, l_cnt;
  logic          dir_up, dir_dn;   // newest confirm entries all up / all down
  entry_t        rdata;
  logic [AW-1:0] raddr;
  div_req_t      dreq;
  logic          ddone;
  logic [PW-1:0] dq;
  logic [PW-1:0] s_avg;
  logic          up;
  logic          scan_more;

  always_ff @(posedge clk) begin
    if (rst) begin
      short_min <= MW'(5);
      long_min <= MW'(20);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SHORT: short_min <= cfg_data;
        REG_LONG:  long_min <= cfg_data;
        default: ;
      endcase
    end
  end

  assign tick.ready = (state == S_IDLE);
  assign raddr = newest_slot - k[AW-1:0];
  // keep scanning while stored entries remain and a window is open or the confirm run is undecided
  assign scan_more = (k < stored_count) &&
                     ((s_open || l_open) || (k < (AW+1)'(CONFIRM)));

  macs_hist_mem u_mem (
    .clk(clk),
    .we(state == S_WRITE),
    .waddr(newest_slot + AW'(1)),
    .wdata('{t: now, p: price, d: up}),
    .raddr(raddr),
    .rdata(rdata)
  );

  macs_div u_div (.clk(clk), .rst(rst), .req(dreq), .done(ddone), .quotient(dq));

  always_comb begin
    dreq = '{start: 1'b0, dividend: s_sum, divisor: s_cnt};
    if (state == S_SCAN && !scan_more && !rd_pend) dreq.start = 1'b1;
    if (state == S_DIVS && ddone) begin
      dreq = '{start: 1'b1, dividend: l_sum, divisor: l_cnt};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      newest_slot <= '0;
      stored_count <= '0;
      result.valid <= 1'b0;
      rd_pend <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (tick.valid) begin
          // latch the tick; edges are spans of 120*minutes, compared as
          // past + span > now  <=>  past > now - span (wrap-safe below)
          now <= tick.tick_time;
          price <= tick.tick_price;
          short_edge <= TW'(short_min) * TW'(120);
          long_edge <= TW'(long_min) * TW'(120);
          s_sum <= SW'(tick.tick_price);
          l_sum <= SW'(tick.tick_price);
          s_cnt <= CW'(1);
          l_cnt <= CW'(1);
          s_open <= 1'b1;
          l_open <= 1'b1;
          dir_up <= 1'b1;
          dir_dn <= 1'b1;
          k <= '0;
          rd_pend <= 1'b0;
          state <= S_SCAN;
        end
        S_SCAN: begin
          // issue one read a cycle, consume the previous one
          rd_pend <= scan_more;
          k_rd <= k;
          if (scan_more) k <= k + (AW+1)'(1);
          if (rd_pend) begin
            if (s_open && ({1'b0, rdata.t} + {1'b0, short_edge} > {1'b0, now})) begin
              s_sum <= s_sum + SW'(rdata.p);
              s_cnt <= s_cnt + CW'(1);
            end else s_open <= 1'b0;
            if (l_open && ({1'b0, rdata.t} + {1'b0, long_edge} > {1'b0, now})) begin
              l_sum <= l_sum + SW'(rdata.p);
              l_cnt <= l_cnt + CW'(1);
            end else l_open <= 1'b0;
            if (k_rd < (AW+1)'(CONFIRM)) begin
              if (rdata.d) dir_dn <= 1'b0;
              else dir_up <= 1'b0;
            end
          end
          if (!scan_more && !rd_pend) state <= S_DIVS;
        end
        S_DIVS: if (ddone) begin
          s_avg <= dq;
          state <= S_DIVL;
        end
        S_DIVL: if (ddone) begin
          result.short_average <= s_avg;
          result.long_average <= dq;
          result.short_above_long <= s_avg > dq;
          up <= s_avg > dq;
          if (stored_count > (AW+1)'(MIN_HIST) && stored_count >= (AW+1)'(CONFIRM)
              && ((s_avg > dq) ? dir_up : dir_dn))
            result.signal <= (s_avg > dq) ? SIG_BUY : SIG_SELL;
          else
            result.signal <= SIG_NONE;
          state <= S_WRITE;
        end
        S_WRITE: begin
          newest_slot <= newest_slot + AW'(1);
          if (stored_count < (AW+1)'(DEPTH)) stored_count <= stored_count + (AW+1)'(1);
          result.valid <= 1'b1;
          state <= S_OUT;
        end
        S_OUT: if (result.ready) begin
          result.valid <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // the fill count never passes the ring depth
  a_count: assert property (@(posedge clk) disable iff (rst)
    stored_count <= (AW+1)'(DEPTH)) else $error("fill count overflow");
  // a result beat is only offered in the output state
  a_valid: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> state == S_OUT) else $error("result valid outside output");
  // ring advances by one for each stored tick
  a_slot: assert property (@(posedge clk) disable iff (rst)
    state == S_WRITE |=> newest_slot == $past(newest_slot) + AW'(1))
    else $error("slot did not advance");
endmodule
